### sv/assert_macros.svh
// Assertion macros used by the checker module of this block.
// Every macro samples on the rising clock edge and is disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in the same cycle");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed one cycle later");

`endif

### sv/u2g_pkg.sv
// Shared types and constants of the UTF-16 to GBK converter.
// Used by the table memory, the core and the port checker.
`default_nettype none

package u2g_pkg;

    localparam int KEY_W       = 16;
    localparam int VALUE_W     = 16;
    localparam int INDEX_W     = 15;
    localparam int BYTE_W      = 8;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [KEY_W-1:0] ASCII_LIMIT = 16'h0080;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_CONVERT = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_ENTRY_COUNT   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LITTLE_ENDIAN = 1'd1;

    // One table entry: gbk code in the upper half, unicode key in the lower half.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [KEY_W-1:0]   key;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_PROBE = 3'b010,
        ST_EMIT  = 3'b100
    } state_t;

endpackage

`default_nettype wire

### sv/u2g_table.sv
// Conversion table memory: one write port and one read port with registered read data.
// Depends on u2g_pkg for the entry type.
`default_nettype none

module u2g_table #(
    parameter int DEPTH  = 32768,
    parameter int ADDR_W = 15
) (
    input  wire logic               clk,
    input  wire logic               we,
    input  wire logic [ADDR_W-1:0]  waddr,
    input  u2g_pkg::entry_t         wdata,
    input  wire logic [ADDR_W-1:0]  raddr,
    output u2g_pkg::entry_t         rdata
);
    import u2g_pkg::*;

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### sv/utf16_to_gbk_converter_core.sv
// UTF-16 to GBK converter core. A load item writes one table entry if its index is in
// range. A convert item below 0x80 gives at most one output byte; any other is looked up
// with one table probe per cycle (at most PROBE_COUNT, 16 by default) through the single
// read port of the table, then gives at most two output bytes. No new item is taken while one is in work.
// Reset returns state and configuration to their defaults and clears output valid; the table keeps its contents.
`default_nettype none

module utf16_to_gbk_converter_core #(
    parameter int TABLE_DEPTH = 32768,
    parameter int PROBE_COUNT = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [u2g_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [u2g_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  wire logic                                item_valid,
    output logic                                     item_stall,
    input  wire logic                                operation,
    input  wire logic [u2g_pkg::INDEX_W-1:0]         entry_index,
    input  wire logic [u2g_pkg::KEY_W-1:0]           entry_key,
    input  wire logic [u2g_pkg::VALUE_W-1:0]         entry_value,
    input  wire logic [u2g_pkg::BYTE_W-1:0]          first_byte,
    input  wire logic [u2g_pkg::BYTE_W-1:0]          second_byte,
    input  wire logic                                last_unit,
    output logic                                     result_valid,
    input  wire logic                                result_stall,
    output logic [u2g_pkg::BYTE_W-1:0]               gbk_byte,
    output logic                                     byte_valid,
    output logic                                     last_of_item,
    output logic                                     end_of_string
);
    import u2g_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(PROBE_COUNT + 1);
    localparam int XW = (AW + 1 > CFG_DATA_W + 1) ? AW + 1 : CFG_DATA_W + 1;

    state_t state_reg, state_next;

    logic [CFG_DATA_W-1:0] entry_count_reg;
    logic                  little_endian_reg;

    logic [AW-1:0]    lo_reg, lo_next;
    logic [AW-1:0]    hi_reg, hi_next;
    logic [AW-1:0]    mid_reg;
    logic [AW-1:0]    rd_addr;
    logic [CW-1:0]    probe_cnt_reg, probe_cnt_next;
    logic [KEY_W-1:0] unit_reg, unit_next;
    logic [VALUE_W-1:0] code_reg, code_next;
    logic             last_reg, last_next;
    logic             hi_pend_reg, hi_pend_next;

    logic             result_valid_reg;
    logic [BYTE_W-1:0] gbk_byte_reg;
    logic             byte_valid_reg;
    logic             last_of_item_reg;
    logic             end_of_string_reg;

    logic              out_load;
    logic [BYTE_W-1:0] out_byte;
    logic              out_bv;
    logic              out_loi;
    logic              out_eos;
    logic              out_free;

    logic              item_accept;
    logic              tbl_we;
    entry_t            tbl_wdata;
    entry_t            tbl_rdata;
    logic [KEY_W-1:0]  unit_in;
    logic [XW-1:0]     count_ext;
    logic [XW-1:0]     count_clamped;
    logic [AW-1:0]     hi_start;
    logic              idx_in_range;
    logic [BYTE_W-1:0] hb;
    logic [BYTE_W-1:0] lb;

    assign item_accept = item_valid && !item_stall;
    assign item_stall  = (state_reg != ST_IDLE);
    assign out_free    = !result_valid_reg || !result_stall;

    assign unit_in = little_endian_reg ? {second_byte, first_byte} : {first_byte, second_byte};

    // Entry counts of zero and beyond the table are clamped before the search starts.
    always_comb
    begin
        count_ext = XW'(entry_count_reg);
        if (count_ext == '0)
        begin
            count_clamped = XW'(1);
        end
        else if (count_ext > XW'(TABLE_DEPTH))
        begin
            count_clamped = XW'(TABLE_DEPTH);
        end
        else
        begin
            count_clamped = count_ext;
        end
    end

    assign hi_start     = AW'(count_clamped - XW'(1));
    assign idx_in_range = (32'(entry_index) < 32'(TABLE_DEPTH));
    assign tbl_wdata    = '{value: entry_value, key: entry_key};

    assign hb = code_reg[15:8];
    assign lb = code_reg[7:0];

    always_comb
    begin
        state_next     = state_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        probe_cnt_next = probe_cnt_reg;
        unit_next      = unit_reg;
        code_next      = code_reg;
        last_next      = last_reg;
        hi_pend_next   = hi_pend_reg;
        tbl_we         = 1'b0;
        out_load       = 1'b0;
        out_byte       = '0;
        out_bv         = 1'b0;
        out_loi        = 1'b0;
        out_eos        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (item_accept)
                begin
                    if (operation == OP_LOAD)
                    begin
                        tbl_we = idx_in_range;
                    end
                    else
                    begin
                        unit_next      = unit_in;
                        last_next      = last_unit;
                        hi_pend_next   = 1'b1;
                        lo_next        = '0;
                        hi_next        = hi_start;
                        probe_cnt_next = '0;
                        if (unit_in < ASCII_LIMIT)
                        begin
                            code_next  = unit_in;
                            state_next = ST_EMIT;
                        end
                        else
                        begin
                            state_next = ST_PROBE;
                        end
                    end
                end
            end

            ST_PROBE:
            begin
                // The read data belongs to mid_reg; the next probe address is issued now.
                if (tbl_rdata.key == unit_reg)
                begin
                    code_next  = tbl_rdata.value;
                    state_next = ST_EMIT;
                end
                else
                begin
                    if (tbl_rdata.key < unit_reg)
                    begin
                        lo_next = mid_reg;
                    end
                    else
                    begin
                        hi_next = mid_reg;
                    end
                    if (probe_cnt_reg == CW'(PROBE_COUNT - 1))
                    begin
                        code_next  = '0;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        probe_cnt_next = probe_cnt_reg + CW'(1);
                    end
                end
            end

            ST_EMIT:
            begin
                if (hi_pend_reg && (hb != '0))
                begin
                    if (out_free)
                    begin
                        out_load     = 1'b1;
                        out_byte     = hb;
                        out_bv       = 1'b1;
                        out_loi      = (lb == '0);
                        out_eos      = last_reg && (lb == '0);
                        hi_pend_next = 1'b0;
                        if (lb == '0)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
                else if (lb != '0)
                begin
                    if (out_free)
                    begin
                        out_load   = 1'b1;
                        out_byte   = lb;
                        out_bv     = 1'b1;
                        out_loi    = 1'b1;
                        out_eos    = last_reg;
                        state_next = ST_IDLE;
                    end
                end
                else if (last_reg)
                begin
                    // Nothing converted on the final unit: send the empty end marker.
                    if (out_free)
                    begin
                        out_load   = 1'b1;
                        out_loi    = 1'b1;
                        out_eos    = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rd_addr = lo_next + ((hi_next - lo_next) >> 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            entry_count_reg   <= CFG_DATA_W'(1);
            little_endian_reg <= 1'b0;
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ENTRY_COUNT:   entry_count_reg   <= cfg_wdata;
                    REG_LITTLE_ENDIAN: little_endian_reg <= cfg_wdata[0];
                    default:           entry_count_reg   <= entry_count_reg;
                endcase
            end
            if (out_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= rd_addr;
        probe_cnt_reg <= probe_cnt_next;
        unit_reg      <= unit_next;
        code_reg      <= code_next;
        last_reg      <= last_next;
        hi_pend_reg   <= hi_pend_next;
        if (out_load)
        begin
            gbk_byte_reg      <= out_byte;
            byte_valid_reg    <= out_bv;
            last_of_item_reg  <= out_loi;
            end_of_string_reg <= out_eos;
        end
    end

    u2g_table #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (AW)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (AW'(entry_index)),
        .wdata (tbl_wdata),
        .raddr (rd_addr),
        .rdata (tbl_rdata)
    );

    assign result_valid  = result_valid_reg;
    assign gbk_byte      = gbk_byte_reg;
    assign byte_valid    = byte_valid_reg;
    assign last_of_item  = last_of_item_reg;
    assign end_of_string = end_of_string_reg;

endmodule

`default_nettype wire

### sv/u2g_checker.sv
// Port-level checker for the converter core, bound to the top level below.
// Depends on u2g_pkg and on assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module u2g_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          item_valid,
    input wire logic                          item_stall,
    input wire logic                          operation,
    input wire logic                          result_valid,
    input wire logic                          result_stall,
    input wire logic [u2g_pkg::BYTE_W-1:0]    gbk_byte,
    input wire logic                          byte_valid,
    input wire logic                          last_of_item,
    input wire logic                          end_of_string
);
    import u2g_pkg::*;

    // A result that waits for its transfer does not vanish.
    `ASSERT_NEXT(a_result_held, clk, rst_n, result_valid && result_stall, result_valid)

    // The empty result only ever marks the end of a string.
    `ASSERT_SAME(a_marker_form, clk, rst_n, result_valid && !byte_valid,
        last_of_item && end_of_string && (gbk_byte == '0))

    // Zero bytes are never sent as data.
    `ASSERT_SAME(a_no_zero_byte, clk, rst_n, result_valid && byte_valid, gbk_byte != '0)

    `ASSERT_SAME(a_eos_closes_item, clk, rst_n, result_valid && end_of_string, last_of_item)

    // A convert transfer always leaves the block busy once it is taken.
    `ASSERT_NEXT(a_convert_busy, clk, rst_n,
        item_valid && !item_stall && (operation == OP_CONVERT), item_stall)

endmodule

bind utf16_to_gbk_converter_core u2g_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .operation     (operation),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .gbk_byte      (gbk_byte),
    .byte_valid    (byte_valid),
    .last_of_item  (last_of_item),
    .end_of_string (end_of_string)
);

`default_nettype wire
